FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/ire_pkg.sv
// shared types and codes of the interpolated residual engine
package ire_pkg;

    typedef logic [1:0] t_status;

    localparam t_status ST_INTERP  = 2'd0;
    localparam t_status ST_NOBRACK = 2'd1;
    localparam t_status ST_ZEROW   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_FETCH_LO,
        S_FETCH_HI,
        S_SETUP,
        S_MUL,
        S_DIV,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic    load;
        logic    capture;
        logic    search;
        logic    fetch_lo;
        logic    fetch_hi;
        logic    latch_lo;
        logic    setup;
        logic    mul;
        logic    div;
        logic    emit;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic miss;
        logic dx_zero;
        logic mul_last;
        logic div_last;
    } t_sts;

endpackage

FILE: rtl/core/ire_ctrl.sv
// controller state machine of the interpolated residual engine
module ire_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          i_req_type,
    input  ire_pkg::t_sts i_sts,
    output ire_pkg::t_cmd o_cmd,
    output logic          busy
);

    ire_pkg::t_state r_state;
    ire_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ire_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ire_pkg::S_IDLE: begin
                if (start) begin
                    if (i_req_type) begin
                        o_cmd.capture = 1'b1;
                        n_state       = ire_pkg::S_SEARCH;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ire_pkg::S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_sts.hit) begin
                    n_state = ire_pkg::S_FETCH_LO;
                end else if (i_sts.miss) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = ire_pkg::ST_NOBRACK;
                    n_state    = ire_pkg::S_IDLE;
                end
            end
            ire_pkg::S_FETCH_LO: begin
                o_cmd.fetch_lo = 1'b1;
                n_state        = ire_pkg::S_FETCH_HI;
            end
            ire_pkg::S_FETCH_HI: begin
                o_cmd.fetch_hi = 1'b1;
                o_cmd.latch_lo = 1'b1;
                n_state        = ire_pkg::S_SETUP;
            end
            ire_pkg::S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ire_pkg::S_MUL;
            end
            ire_pkg::S_MUL: begin
                if (i_sts.dx_zero) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = ire_pkg::ST_ZEROW;
                    n_state    = ire_pkg::S_IDLE;
                end else begin
                    o_cmd.mul = 1'b1;
                    if (i_sts.mul_last) begin
                        n_state = ire_pkg::S_DIV;
                    end
                end
            end
            ire_pkg::S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ire_pkg::S_FINISH;
                end
            end
            ire_pkg::S_FINISH: begin
                o_cmd.emit = 1'b1;
                o_cmd.code = ire_pkg::ST_INTERP;
                n_state    = ire_pkg::S_IDLE;
            end
            default: begin
                n_state = ire_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ire_pkg::S_IDLE);

endmodule

FILE: rtl/core/ire_dpath.sv
// datapath: curve table, search, shift-add multiplier and restoring divider
module ire_dpath #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 40
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ire_pkg::t_cmd          i_cmd,
    input  logic signed [VALUE_WIDTH-1:0] i_point_x,
    input  logic signed [VALUE_WIDTH-1:0] i_point_y,
    input  logic                   i_first_of_table,
    output ire_pkg::t_sts          o_sts,
    output logic signed [VALUE_WIDTH-1:0] o_residual,
    output ire_pkg::t_status       o_status,
    output logic                   o_strobe
);

    localparam int V  = VALUE_WIDTH;
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = 2 * VALUE_WIDTH;
    localparam int NW = $clog2(PW);
    localparam int RW = PW + 2;

    logic [V-1:0] mem_x [TABLE_DEPTH];
    logic [V-1:0] mem_y [TABLE_DEPTH];

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         r_pend_idx;
    logic                  r_pend;
    logic signed [V-1:0]   r_xq, r_yq;
    logic signed [V-1:0]   r_qx, r_qy, r_x0, r_y0;
    logic [PW-1:0]         r_a, r_acc;
    logic [V-1:0]          r_b, r_d, r_rem;
    logic                  r_neg, r_dxz;
    logic [NW-1:0]         r_cnt;
    logic signed [V-1:0]   r_residual;
    ire_pkg::t_status      r_status;
    logic                  r_strobe;

    logic [AW-1:0]         n_raddr;
    logic                  s_issue, s_hit, s_wr;
    logic [AW-1:0]         s_waddr;
    logic signed [V:0]     s_num, s_dy, s_dx;
    logic [V:0]            s_num_m, s_dy_m, s_dx_m;
    logic [V:0]            s_sh, s_trial;
    logic signed [RW-1:0]  s_q, s_res;
    ire_pkg::t_status      n_status;
    logic signed [V-1:0]   n_residual;

    localparam logic signed [RW-1:0] MaxV = RW'((64'sd1 <<< (V - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] MinV = -MaxV - RW'(1);

    assign s_hit   = r_pend && (r_xq > r_qx);
    assign s_issue = i_cmd.search && !s_hit && (r_idx < r_count);
    assign s_wr    = i_cmd.load && (i_first_of_table || (r_count < CW'(TABLE_DEPTH)));
    assign s_waddr = i_first_of_table ? '0 : r_count[AW-1:0];

    always_comb begin
        if (i_cmd.fetch_lo) begin
            n_raddr = AW'(r_pend_idx - CW'(1));
        end else if (i_cmd.fetch_hi) begin
            n_raddr = r_pend_idx[AW-1:0];
        end else begin
            n_raddr = r_idx[AW-1:0];
        end
    end

    // table storage
    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            mem_x[s_waddr] <= i_point_x;
            mem_y[s_waddr] <= i_point_y;
        end
        r_xq <= mem_x[n_raddr];
        r_yq <= mem_y[n_raddr];
    end

    always_comb begin
        s_num   = {r_qx[V-1], r_qx} - {r_x0[V-1], r_x0};
        s_dy    = {r_yq[V-1], r_yq} - {r_y0[V-1], r_y0};
        s_dx    = {r_xq[V-1], r_xq} - {r_x0[V-1], r_x0};
        s_num_m = s_num[V] ? -s_num : s_num;
        s_dy_m  = s_dy[V] ? -s_dy : s_dy;
        s_dx_m  = s_dx[V] ? -s_dx : s_dx;
        s_sh    = {r_rem, r_acc[PW-1]};
        s_trial = s_sh - {1'b0, r_d};
        s_q     = r_neg ? -$signed({2'b00, r_acc}) : $signed({2'b00, r_acc});
        s_res   = $signed({{(RW-V){r_qy[V-1]}}, r_qy})
                - $signed({{(RW-V){r_y0[V-1]}}, r_y0}) - s_q;
        n_status = i_cmd.code;
        case (i_cmd.code)
            ire_pkg::ST_INTERP: begin
                if (s_res > MaxV) begin
                    n_residual = MaxV[V-1:0];
                end else if (s_res < MinV) begin
                    n_residual = MinV[V-1:0];
                end else begin
                    n_residual = s_res[V-1:0];
                end
            end
            default: begin
                n_residual = r_qy;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (s_wr) begin
                r_count <= i_first_of_table ? CW'(1) : r_count + CW'(1);
            end
            if (i_cmd.capture) begin
                r_pend <= 1'b0;
            end else if (i_cmd.search && !s_hit) begin
                r_pend <= s_issue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_qx  <= i_point_x;
            r_qy  <= i_point_y;
            r_idx <= CW'(1);
        end
        if (s_issue) begin
            r_pend_idx <= r_idx;
            r_idx      <= r_idx + CW'(1);
        end
        if (i_cmd.latch_lo) begin
            r_x0 <= r_xq;
            r_y0 <= r_yq;
        end
        if (i_cmd.setup) begin
            r_a   <= {{(PW-V){1'b0}}, s_num_m[V-1:0]};
            r_b   <= s_dy_m[V-1:0];
            r_d   <= s_dx_m[V-1:0];
            r_neg <= s_num[V] ^ s_dy[V] ^ s_dx[V];
            r_dxz <= (s_dx == '0);
            r_acc <= '0;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.mul) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a   <= r_a << 1;
            r_b   <= r_b >> 1;
            r_cnt <= (r_cnt == NW'(V - 1)) ? '0 : r_cnt + NW'(1);
        end
        if (i_cmd.div) begin
            if (!s_trial[V]) begin
                r_rem <= s_trial[V-1:0];
                r_acc <= {r_acc[PW-2:0], 1'b1};
            end else begin
                r_rem <= s_sh[V-1:0];
                r_acc <= {r_acc[PW-2:0], 1'b0};
            end
            r_cnt <= r_cnt + NW'(1);
        end
        if (i_cmd.emit) begin
            r_residual <= n_residual;
            r_status   <= n_status;
        end
    end

    assign o_sts.hit      = s_hit;
    assign o_sts.miss     = !r_pend && (r_idx >= r_count);
    assign o_sts.dx_zero  = r_dxz;
    assign o_sts.mul_last = (r_cnt == NW'(V - 1));
    assign o_sts.div_last = (r_cnt == NW'(PW - 1));
    assign o_residual     = r_residual;
    assign o_status       = r_status;
    assign o_strobe       = r_strobe;

endmodule

FILE: rtl/core/interpolated_residual_engine.sv
// top level of the interpolated residual engine
// a load beat leaves busy low and the next beat may follow at once
// a query raises busy and scans the table entries for a pair that brackets its x;
// the scan reads one table entry a cycle through the single memory read port
// then a one-bit-a-cycle multiplier and divider form the result; the result strobe is one cycle
// synchronous active-low reset empties the table and returns the controller to idle
module interpolated_residual_engine #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 40
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_req_type,
    input  logic signed [VALUE_WIDTH-1:0] i_point_x,
    input  logic signed [VALUE_WIDTH-1:0] i_point_y,
    input  logic                          i_first_of_table,
    output logic                          o_strobe,
    output logic signed [VALUE_WIDTH-1:0] o_residual,
    output logic [1:0]                    o_status
);

    ire_pkg::t_cmd s_cmd;
    ire_pkg::t_sts s_sts;

    ire_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd),
        .busy       (busy)
    );

    ire_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (s_cmd),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .i_first_of_table (i_first_of_table),
        .o_sts            (s_sts),
        .o_residual       (o_residual),
        .o_status         (o_status),
        .o_strobe         (o_strobe)
    );

endmodule

FILE: rtl/core/ire_checker.sv
// port-level checks of the interpolated residual engine and their binding
`include "assert_macros.svh"

module ire_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_req_type,
    input logic       o_strobe,
    input logic [1:0] o_status
);

    `ASSERT_IMP(a_strobe_after_busy, i_clk, i_rst_n, o_strobe, $past(busy))
    `ASSERT_NXT(a_single_strobe, i_clk, i_rst_n, o_strobe, !o_strobe)
    `ASSERT_IMP(a_status_legal, i_clk, i_rst_n, o_strobe, o_status != 2'd3)
    `ASSERT_NXT(a_query_busy, i_clk, i_rst_n, start && !busy && i_req_type, busy && !o_strobe)
    `ASSERT_NXT(a_load_quiet, i_clk, i_rst_n, start && !busy && !i_req_type, !busy && !o_strobe)

endmodule

bind interpolated_residual_engine ire_checker u_ire_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_req_type (i_req_type),
    .o_strobe   (o_strobe),
    .o_status   (o_status)
);
